FILE: src/tve_pkg.sv
package tve_pkg;

    // Width of one limb of the split multipliers.
    localparam int LIMB_W = 24;

    // The sum is divided by 144 = 9 * 16 and then shifted right by 32.
    localparam int DIV_SHIFT = 36;

    // The divide-by-nine pipeline works on nibbles, most significant first.
    localparam int DIV_IN_W    = 68;
    localparam int DIV_STAGES  = 5;
    localparam int DIV_PER     = 4;
    localparam int DIV_PAD_W   = DIV_STAGES * DIV_PER * 4;

    // The square root pipeline retires two result bits per stage.
    localparam int Q_W         = 64;
    localparam int VOL_W       = 32;
    localparam int SQRT_STAGES = 16;
    localparam int SQRT_PER    = 2;

    // Status that travels with a word through the back end.
    typedef struct packed {
        logic degen;
        logic sat;
    } t_flags;

endpackage

FILE: src/tetrahedron_volume_from_edges.sv
// Throughput: one word per cycle while the output is taken; each stage holds
// until the next one frees, so the pipe keeps accepting while a finished word
// waits at the output, until every stage holds a word.
// The depth comes from the split wide multipliers, the nibble-serial divide
// by nine and the two-bits-per-stage square root.
// Reset: i_rst_n is synchronous and active low; it clears all valid bits.
module tetrahedron_volume_from_edges #(
    parameter int EDGE_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // edge_12, edge_13, edge_14, edge_23, edge_24, edge_34 from the lowest bit up
    input  logic [((6*EDGE_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // volume
    output logic [tve_pkg::VOL_W-1:0]             o_m_axis_tdata,
    // degenerate
    output logic [0:0]                            o_m_axis_tuser
);
    import tve_pkg::*;

    localparam int EW   = EDGE_WIDTH;
    localparam int SQW  = 2 * EW;
    localparam int FW   = SQW + 3;
    localparam int FMW  = SQW + 2;
    localparam int PRW  = 4 * EW;
    localparam int GW   = PRW + 1;
    localparam int TW   = 6 * EW + 2;
    localparam int SW   = 6 * EW + 5;
    localparam int EEW  = SW - DIV_SHIFT;
    localparam int EXW  = (EEW > DIV_IN_W + 1) ? EEW : DIV_IN_W + 1;
    localparam int ST_DIV  = 11;
    localparam int ST_SQRT = ST_DIV + DIV_STAGES;
    localparam int NST     = ST_SQRT + SQRT_STAGES + 1;

    // Stage valid bits and enables.
    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_s_axis_tvalid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_v[NST-1];

    // Stage 0: square every edge.
    logic [SQW-1:0] r_sq [6];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < 6; i++) begin
                r_sq[i] <= SQW'(i_s_axis_tdata[i*EW +: EW]) * SQW'(i_s_axis_tdata[i*EW +: EW]);
            end
        end
    end

    // Opposite pairs: a = 12 with A = 34, b = 13 with B = 24, c = 14 with C = 23.
    logic [PRW-1:0] p_bC, p_cB, p_bc, p_BC, p_aA, p_bB, p_cC;

    tve_mul #(.AW(SQW), .BW(SQW)) u_m_bC (.i_clk(i_clk), .i_en(en[3:1]),
        .i_a(r_sq[1]), .i_b(r_sq[3]), .o_p(p_bC));
    tve_mul #(.AW(SQW), .BW(SQW)) u_m_cB (.i_clk(i_clk), .i_en(en[3:1]),
        .i_a(r_sq[2]), .i_b(r_sq[4]), .o_p(p_cB));
    tve_mul #(.AW(SQW), .BW(SQW)) u_m_bc (.i_clk(i_clk), .i_en(en[3:1]),
        .i_a(r_sq[1]), .i_b(r_sq[2]), .o_p(p_bc));
    tve_mul #(.AW(SQW), .BW(SQW)) u_m_BC (.i_clk(i_clk), .i_en(en[3:1]),
        .i_a(r_sq[4]), .i_b(r_sq[3]), .o_p(p_BC));
    tve_mul #(.AW(SQW), .BW(SQW)) u_m_aA (.i_clk(i_clk), .i_en(en[3:1]),
        .i_a(r_sq[0]), .i_b(r_sq[5]), .o_p(p_aA));
    tve_mul #(.AW(SQW), .BW(SQW)) u_m_bB (.i_clk(i_clk), .i_en(en[3:1]),
        .i_a(r_sq[1]), .i_b(r_sq[4]), .o_p(p_bB));
    tve_mul #(.AW(SQW), .BW(SQW)) u_m_cC (.i_clk(i_clk), .i_en(en[3:1]),
        .i_a(r_sq[2]), .i_b(r_sq[3]), .o_p(p_cC));

    // Stage 1: the linear factors, e.g. b + B + c + C - a - A, as sign and magnitude.
    logic [FW-1:0]  n_fs [3];
    logic [FMW-1:0] r_fm [1:4][3];
    logic           r_fn [1:7][3];
    logic [SQW-1:0] r_sa [1:4];
    logic [SQW-1:0] r_sA [1:4];

    always_comb begin
        logic [FW-1:0] pa, pb, pc;
        pa = FW'(r_sq[0]) + FW'(r_sq[5]);
        pb = FW'(r_sq[1]) + FW'(r_sq[4]);
        pc = FW'(r_sq[2]) + FW'(r_sq[3]);
        n_fs[0] = pb + pc - pa;
        n_fs[1] = pa + pc - pb;
        n_fs[2] = pa + pb - pc;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_fn[1][i] <= n_fs[i][FW-1];
                r_fm[1][i] <= n_fs[i][FW-1] ? FMW'(-n_fs[i]) : FMW'(n_fs[i]);
            end
            r_sa[1] <= r_sq[0];
            r_sA[1] <= r_sq[5];
        end
        for (int k = 2; k <= 4; k++) begin
            if (en[k]) begin
                r_fm[k] <= r_fm[k-1];
                r_sa[k] <= r_sa[k-1];
                r_sA[k] <= r_sA[k-1];
            end
        end
        for (int k = 2; k <= 7; k++) begin
            if (en[k]) begin
                r_fn[k] <= r_fn[k-1];
            end
        end
    end

    // Stage 4: the pair-product sums bC + cB and bc + BC, and the opposite-pair products.
    logic [GW-1:0]  r_g1, r_g2;
    logic [PRW-1:0] r_aA, r_bB, r_cC;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_g1 <= GW'(p_bC) + GW'(p_cB);
            r_g2 <= GW'(p_bc) + GW'(p_BC);
            r_aA <= p_aA;
            r_bB <= p_bB;
            r_cC <= p_cC;
        end
    end

    // Stages 5 to 7: the five triple products.
    logic [TW-1:0]   t1, t2, t3;
    logic [TW-2:0]   t4, t5;

    tve_mul #(.AW(PRW), .BW(FMW)) u_m_t1 (.i_clk(i_clk), .i_en(en[7:5]),
        .i_a(r_aA), .i_b(r_fm[4][0]), .o_p(t1));
    tve_mul #(.AW(PRW), .BW(FMW)) u_m_t2 (.i_clk(i_clk), .i_en(en[7:5]),
        .i_a(r_bB), .i_b(r_fm[4][1]), .o_p(t2));
    tve_mul #(.AW(PRW), .BW(FMW)) u_m_t3 (.i_clk(i_clk), .i_en(en[7:5]),
        .i_a(r_cC), .i_b(r_fm[4][2]), .o_p(t3));
    tve_mul #(.AW(SQW), .BW(GW)) u_m_t4 (.i_clk(i_clk), .i_en(en[7:5]),
        .i_a(r_sa[4]), .i_b(r_g1), .o_p(t4));
    tve_mul #(.AW(SQW), .BW(GW)) u_m_t5 (.i_clk(i_clk), .i_en(en[7:5]),
        .i_a(r_sA[4]), .i_b(r_g2), .o_p(t5));

    // Stage 8: positive and negative parts of the sum, kept apart.
    logic [SW-1:0] r_pos, r_neg;

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_pos <= (r_fn[7][0] ? '0 : SW'(t1)) + (r_fn[7][1] ? '0 : SW'(t2))
                   + (r_fn[7][2] ? '0 : SW'(t3));
            r_neg <= SW'(t4) + SW'(t5) + (r_fn[7][0] ? SW'(t1) : '0)
                   + (r_fn[7][1] ? SW'(t2) : '0) + (r_fn[7][2] ? SW'(t3) : '0);
        end
    end

    // Stage 9: the sign of the sum and the difference of its two parts.
    logic          r_dg9;
    logic [SW-1:0] r_diff;

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_dg9  <= r_pos < r_neg;
            r_diff <= r_pos - r_neg;
        end
    end

    // Stage 10: drop the factor of sixteen and the 32 fraction bits; catch overflow.
    logic [EXW-1:0]      ee;
    logic [DIV_IN_W-1:0] r_num;
    t_flags              r_flg10;

    assign ee = EXW'(r_diff >> DIV_SHIFT);

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            r_num         <= ee[DIV_IN_W-1:0];
            r_flg10.degen <= r_dg9;
            r_flg10.sat   <= ee[EXW-1:Q_W] >= (EXW-Q_W)'(9);
        end
    end

    // Divide by nine, then take the square root.
    logic [Q_W-1:0]   quo;
    logic [VOL_W-1:0] root;
    t_flags           flg_d, flg_s;

    tve_div9 u_div9 (
        .i_clk   (i_clk),
        .i_en    (en[ST_DIV +: DIV_STAGES]),
        .i_num   (r_num),
        .i_flags (r_flg10),
        .o_quo   (quo),
        .o_flags (flg_d)
    );

    tve_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_en    (en[ST_SQRT +: SQRT_STAGES]),
        .i_val   (quo),
        .i_flags (flg_d),
        .o_root  (root),
        .o_flags (flg_s)
    );

    // Output register: zero for an impossible shape, all ones on overflow.
    logic [VOL_W-1:0] r_vol;
    logic             r_degen;

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) begin
            r_degen <= flg_s.degen;
            if (flg_s.degen) begin
                r_vol <= '0;
            end else if (flg_s.sat) begin
                r_vol <= '1;
            end else begin
                r_vol <= root;
            end
        end
    end

    assign o_m_axis_tdata = r_vol;
    assign o_m_axis_tuser = r_degen;

endmodule

FILE: src/tve_mul.sv
module tve_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic            i_clk,
    input  logic [2:0]      i_en,
    input  logic [AW-1:0]   i_a,
    input  logic [BW-1:0]   i_b,
    output logic [AW+BW-1:0] o_p
);
    import tve_pkg::*;

    localparam int NA   = (AW + LIMB_W - 1) / LIMB_W;
    localparam int NB   = (BW + LIMB_W - 1) / LIMB_W;
    localparam int PPW  = 2 * LIMB_W;
    localparam int RW   = LIMB_W * (NB + 1);
    localparam int SUMW = LIMB_W * (NA + NB + 1);
    localparam int PW   = AW + BW;

    logic [NA*LIMB_W-1:0] ap;
    logic [NB*LIMB_W-1:0] bp;
    logic [PPW-1:0]       r_pp [NA][NB];
    logic [RW-1:0]        n_row [NA];
    logic [RW-1:0]        r_row [NA];
    logic [SUMW-1:0]      n_acc;
    logic [PW-1:0]        r_p;

    assign ap = (NA*LIMB_W)'(i_a);
    assign bp = (NB*LIMB_W)'(i_b);

    // First stage: every limb pair is multiplied on its own.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= PPW'(ap[i*LIMB_W +: LIMB_W]) * PPW'(bp[j*LIMB_W +: LIMB_W]);
                end
            end
        end
    end

    // Second stage: the partial products of one row are summed.
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (RW'(r_pp[i][j]) << (LIMB_W * j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_row <= n_row;
        end
    end

    // Third stage: the rows are summed into the full product.
    always_comb begin
        n_acc = '0;
        for (int i = 0; i < NA; i++) begin
            n_acc = n_acc + (SUMW'(r_row[i]) << (LIMB_W * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_p <= n_acc[PW-1:0];
        end
    end

    assign o_p = r_p;

endmodule

FILE: src/tve_div9.sv
module tve_div9 (
    input  logic                           i_clk,
    input  logic [tve_pkg::DIV_STAGES-1:0] i_en,
    input  logic [tve_pkg::DIV_IN_W-1:0]   i_num,
    input  tve_pkg::t_flags                i_flags,
    output logic [tve_pkg::Q_W-1:0]        o_quo,
    output tve_pkg::t_flags                o_flags
);
    import tve_pkg::*;

    localparam int NIBS = DIV_PAD_W / 4;

    logic [DIV_PAD_W-1:0] r_num [DIV_STAGES];
    logic [DIV_PAD_W-1:0] r_quo [DIV_STAGES];
    logic [3:0]           r_rem [DIV_STAGES];
    t_flags               r_flg [DIV_STAGES];
    logic [DIV_PAD_W-1:0] n_num [DIV_STAGES];
    logic [DIV_PAD_W-1:0] n_quo [DIV_STAGES];
    logic [3:0]           n_rem [DIV_STAGES];

    // Quotient digit of a value below 144 divided by nine.
    function automatic logic [3:0] div9_digit(input logic [7:0] cur);
        logic [3:0] q;
        q = '0;
        for (int k = 1; k < 16; k++) begin
            if (cur >= 8'(9 * k)) begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    // Each stage does four long-division steps of one nibble each.
    always_comb begin
        logic [7:0] cur;
        logic [3:0] q;
        logic [3:0] rem;
        int         idx;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                n_num[s] = DIV_PAD_W'(i_num);
                n_quo[s] = '0;
                rem      = '0;
            end else begin
                n_num[s] = r_num[s-1];
                n_quo[s] = r_quo[s-1];
                rem      = r_rem[s-1];
            end
            for (int k = 0; k < DIV_PER; k++) begin
                idx = NIBS - 1 - (s * DIV_PER + k);
                cur = {rem, n_num[s][idx*4 +: 4]};
                q   = div9_digit(cur);
                rem = 4'(cur - 8'(q) * 8'(9));
                n_quo[s][idx*4 +: 4] = q;
            end
            n_rem[s] = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (i_en[s]) begin
                r_num[s] <= n_num[s];
                r_quo[s] <= n_quo[s];
                r_rem[s] <= n_rem[s];
                r_flg[s] <= (s == 0) ? i_flags : r_flg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    assign o_quo   = r_quo[DIV_STAGES-1][Q_W-1:0];
    assign o_flags = r_flg[DIV_STAGES-1];

endmodule

FILE: src/tve_sqrt.sv
module tve_sqrt (
    input  logic                            i_clk,
    input  logic [tve_pkg::SQRT_STAGES-1:0] i_en,
    input  logic [tve_pkg::Q_W-1:0]         i_val,
    input  tve_pkg::t_flags                 i_flags,
    output logic [tve_pkg::VOL_W-1:0]       o_root,
    output tve_pkg::t_flags                 o_flags
);
    import tve_pkg::*;

    localparam int REMW = VOL_W + 4;

    logic [Q_W-1:0]   r_val  [SQRT_STAGES];
    logic [REMW-1:0]  r_rem  [SQRT_STAGES];
    logic [VOL_W-1:0] r_root [SQRT_STAGES];
    t_flags           r_flg  [SQRT_STAGES];
    logic [Q_W-1:0]   n_val  [SQRT_STAGES];
    logic [REMW-1:0]  n_rem  [SQRT_STAGES];
    logic [VOL_W-1:0] n_root [SQRT_STAGES];

    // Restoring square root: two operand bits enter and one root bit leaves per step.
    always_comb begin
        logic [REMW-1:0]  rem;
        logic [REMW-1:0]  trial;
        logic [VOL_W-1:0] root;
        logic [Q_W-1:0]   v;
        for (int s = 0; s < SQRT_STAGES; s++) begin
            if (s == 0) begin
                v    = i_val;
                rem  = '0;
                root = '0;
            end else begin
                v    = r_val[s-1];
                rem  = r_rem[s-1];
                root = r_root[s-1];
            end
            for (int k = 0; k < SQRT_PER; k++) begin
                rem   = {rem[REMW-3:0], v[Q_W-1 -: 2]};
                v     = {v[Q_W-3:0], 2'b00};
                trial = REMW'({root, 2'b01});
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[VOL_W-2:0], 1'b1};
                end else begin
                    root = {root[VOL_W-2:0], 1'b0};
                end
            end
            n_val[s]  = v;
            n_rem[s]  = rem;
            n_root[s] = root;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SQRT_STAGES; s++) begin
            if (i_en[s]) begin
                r_val[s]  <= n_val[s];
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_flg[s]  <= (s == 0) ? i_flags : r_flg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    assign o_root  = r_root[SQRT_STAGES-1];
    assign o_flags = r_flg[SQRT_STAGES-1];

endmodule
